// ===== hdl/glp_pkg.sv =====
package glp_pkg;

  // grid geometry and data widths
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;
  localparam int ELEV_W      = 16;
  localparam int CNT_W       = 8;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CFG_IDX_W   = 1;

  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic signed [ELEV_W-1:0] elev_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_e;

  // one verdict item
  typedef struct packed {
    row_t row;
    col_t column;
    logic is_peak;
    logic frame_end;
  } verdict_t;

  // clamp a count register to 1..maxv
  function automatic cnt_t clamp_count(cnt_t v, cnt_t maxv);
    cnt_t r;
    if (v == '0) begin
      r = cnt_t'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/glp_ram.sv =====
module glp_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/glp_core.sv =====
module glp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  glp_pkg::elev_t    elevation_i,
  input  logic              drain_i,
  input  glp_pkg::cnt_t     row_count_i,
  input  glp_pkg::cnt_t     column_count_i,
  output logic              res_valid_o,
  output glp_pkg::verdict_t res_o
);
  import glp_pkg::*;

  // position and phase
  col_t  cur_col_q, cur_col_d;
  row_t  cur_row_q, cur_row_d;
  logic  draining_q, draining_d;
  elev_t left_q, left_d;

  // same-cycle write forwarding for the prefetched window
  logic  fwd_a_q, fwd_b_q, fwd_s_q;
  elev_t fwd_px_q, fwd_cw_q;

  cnt_t  rows_eff, cols_eff, col_next_cnt, row_next_cnt;
  logic  take_px, take_dr, step, last_col, last_row;
  logic  left_exists, right_exists, up_exists, peak;
  col_t  ra_a, ra_b;
  elev_t rd_a, rd_b, rd_s;
  elev_t center, right, up;
  row_t  judged_row;

  assign rows_eff = clamp_count(row_count_i, cnt_t'(MAX_ROWS));
  assign cols_eff = clamp_count(column_count_i, cnt_t'(MAX_COLUMNS));

  assign take_px = accept_i && !drain_i && !draining_q;
  assign take_dr = accept_i && drain_i && draining_q;
  assign step    = take_px || take_dr;

  assign col_next_cnt = cnt_t'(cur_col_q) + cnt_t'(1);
  assign row_next_cnt = cnt_t'(cur_row_q) + cnt_t'(1);
  assign last_col     = col_next_cnt >= cols_eff;
  assign last_row     = row_next_cnt >= rows_eff;

  // window around the judged cell
  assign center = fwd_a_q ? fwd_px_q : rd_a;
  assign right  = fwd_b_q ? fwd_px_q : rd_b;
  assign up     = fwd_s_q ? fwd_cw_q : rd_s;

  assign left_exists  = cur_col_q != '0;
  assign right_exists = !last_col;
  assign up_exists    = draining_q ? (cur_row_q != '0) : (cur_row_q >= row_t'(2));
  assign judged_row   = draining_q ? cur_row_q : cur_row_q - row_t'(1);

  // peak decision, ties count as peaks
  always_comb begin
    peak = 1'b1;
    if (left_exists && (center < left_q)) peak = 1'b0;
    if (right_exists && (center < right)) peak = 1'b0;
    if (up_exists && (center < up)) peak = 1'b0;
    if (!draining_q && (center < elevation_i)) peak = 1'b0;
  end

  assign res_valid_o     = take_dr || (take_px && (cur_row_q != '0));
  assign res_o.row       = judged_row;
  assign res_o.column    = cur_col_q;
  assign res_o.is_peak   = peak;
  assign res_o.frame_end = take_dr && last_col;

  // next position
  always_comb begin
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    draining_d = draining_q;
    left_d     = left_q;
    if (take_px) begin
      if (last_col) begin
        cur_col_d = '0;
        left_d    = '0;
        if (last_row) begin
          draining_d = 1'b1;
        end else begin
          cur_row_d = cur_row_q + row_t'(1);
        end
      end else begin
        cur_col_d = cur_col_q + col_t'(1);
        left_d    = center;
      end
    end else if (take_dr) begin
      if (last_col) begin
        draining_d = 1'b0;
        cur_col_d  = '0;
        cur_row_d  = '0;
        left_d     = '0;
      end else begin
        cur_col_d = cur_col_q + col_t'(1);
        left_d    = center;
      end
    end
  end

  // prefetch the window of the next cell
  assign ra_a = cur_col_d;
  assign ra_b = cur_col_d + col_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      draining_q <= 1'b0;
      left_q     <= '0;
      fwd_a_q    <= 1'b0;
      fwd_b_q    <= 1'b0;
      fwd_s_q    <= 1'b0;
    end else begin
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      draining_q <= draining_d;
      left_q     <= left_d;
      if (step) begin
        fwd_a_q <= take_px && (ra_a == cur_col_q);
        fwd_b_q <= take_px && (ra_b == cur_col_q);
        fwd_s_q <= take_px && (ra_a == cur_col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      fwd_px_q <= elevation_i;
      fwd_cw_q <= center;
    end
  end

  // previous row, two copies for the center and right reads
  glp_ram #(.Width(ELEV_W), .Depth(MAX_COLUMNS)) u_prev_a (
    .clk_i   (clk_i),
    .we_i    (take_px),
    .waddr_i (cur_col_q),
    .wdata_i (elevation_i),
    .re_i    (step),
    .raddr_i (ra_a),
    .rdata_o (rd_a)
  );

  glp_ram #(.Width(ELEV_W), .Depth(MAX_COLUMNS)) u_prev_b (
    .clk_i   (clk_i),
    .we_i    (take_px),
    .waddr_i (cur_col_q),
    .wdata_i (elevation_i),
    .re_i    (step),
    .raddr_i (ra_b),
    .rdata_o (rd_b)
  );

  // row before the previous one
  glp_ram #(.Width(ELEV_W), .Depth(MAX_COLUMNS)) u_prev2 (
    .clk_i   (clk_i),
    .we_i    (take_px),
    .waddr_i (cur_col_q),
    .wdata_i (center),
    .re_i    (step),
    .raddr_i (ra_a),
    .rdata_o (rd_s)
  );

`ifndef NO_ASSERTIONS
  a_frame_end_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_end |-> draining_q)
    else $error("frame end outside drain phase");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_dr && last_col |=> !draining_q && (cur_col_q == '0) && (cur_row_q == '0))
    else $error("drain phase did not close after final column");
`endif

endmodule

// ===== hdl/glp_out.sv =====
module glp_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  glp_pkg::verdict_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output glp_pkg::verdict_t out_data_o
);
  import glp_pkg::*;

  logic     out_valid_q, skid_valid_q;
  verdict_t out_q, skid_q;
  logic     pop;

  assign pop = out_valid_q && !out_stall_i;

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= push_i;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= push_i;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload moves
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) skid_q <= push_data_i;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (!out_valid_q) begin
      if (push_i) out_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without head entry");

  a_skid_promote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && skid_valid_q |=> out_valid_q && (out_q == $past(skid_q)))
    else $error("skid entry not moved to head");
`endif

endmodule

// ===== hdl/grid_local_peak_detect.sv =====
// a verdict is registered into the output or skid entry as its item is accepted
// throughput: one item per cycle while in_stall_o is low, by prefetching row buffers
// output register plus one skid entry; input stalls only while the skid entry is full
// reset clears position, drain phase and output state; both counts reset to 1
// row buffers have no reset and are only used where they were written earlier
module grid_local_peak_detect (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [glp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  glp_pkg::cnt_t                        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  glp_pkg::elev_t                       elevation_i,
  input  logic                                 drain_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output glp_pkg::row_t                        cell_row_o,
  output glp_pkg::col_t                        cell_column_o,
  output logic                                 is_peak_o,
  output logic                                 frame_end_o
);
  import glp_pkg::*;

  cnt_t     row_count_q, column_count_q;
  logic     accept, res_valid, skid_full;
  verdict_t res, out_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= cnt_t'(1);
      column_count_q <= cnt_t'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default:          row_count_q    <= row_count_q;
      endcase
    end
  end

  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  glp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .elevation_i    (elevation_i),
    .drain_i        (drain_i),
    .row_count_i    (row_count_q),
    .column_count_i (column_count_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  glp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign cell_row_o    = out_data.row;
  assign cell_column_o = out_data.column;
  assign is_peak_o     = out_data.is_peak;
  assign frame_end_o   = out_data.frame_end;

endmodule
